// File: rtl/convection_face_lumped_load_macros.svh
// Assertion macros shared by the face contribution RTL.
`ifndef CONVECTION_FACE_LUMPED_LOAD_MACROS_SVH
`define CONVECTION_FACE_LUMPED_LOAD_MACROS_SVH
`ifndef SYNTH
`define CFLF_CHECK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("cflf check failed");
`define CFLF_CHECK_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cflf implication failed");
`define CFLF_CHECK_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cflf next-cycle check failed");
`else
`define CFLF_CHECK(lbl, prop)
`define CFLF_CHECK_IMP(lbl, ante, cons)
`define CFLF_CHECK_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/cflf_pkg.sv
// Shared types, codes and micro-program for the face contribution block.
`timescale 1ns / 1ps
package cflf_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_H = 2'd0;
	localparam logic [1:0] REG_T = 2'd1;
	localparam logic [1:0] REG_N = 2'd2;

	localparam logic [31:0] H_RESET = 32'd0;
	localparam logic [31:0] T_RESET = 32'd19211878;
	localparam logic [24:0] N_RESET = 25'd16777216;

	// triangle selection
	localparam logic [1:0] TRI_012 = 2'd0;
	localparam logic [1:0] TRI_013 = 2'd1;
	localparam logic [1:0] TRI_123 = 2'd2;

	// micro-op kinds
	localparam logic [3:0] K_NOP  = 4'd0;
	localparam logic [3:0] K_EDGE = 4'd1;
	localparam logic [3:0] K_MUL  = 4'd2;
	localparam logic [3:0] K_MAG  = 4'd3;
	localparam logic [3:0] K_SQRT = 4'd4;
	localparam logic [3:0] K_NSUM = 4'd5;
	localparam logic [3:0] K_DIV  = 4'd6;
	localparam logic [3:0] K_DSAT = 4'd7;
	localparam logic [3:0] K_LOAD = 4'd8;

	// multiplier operand A
	localparam logic [2:0] A_U0 = 3'd0;
	localparam logic [2:0] A_U1 = 3'd1;
	localparam logic [2:0] A_U2 = 3'd2;
	localparam logic [2:0] A_CH = 3'd3;
	localparam logic [2:0] A_CL = 3'd4;
	localparam logic [2:0] A_H  = 3'd5;
	localparam logic [2:0] A_DH = 3'd6;
	localparam logic [2:0] A_DL = 3'd7;

	// multiplier operand B
	localparam logic [2:0] B_W0  = 3'd0;
	localparam logic [2:0] B_W1  = 3'd1;
	localparam logic [2:0] B_W2  = 3'd2;
	localparam logic [2:0] B_CH  = 3'd3;
	localparam logic [2:0] B_CL  = 3'd4;
	localparam logic [2:0] B_AHI = 3'd5;
	localparam logic [2:0] B_ALO = 3'd6;
	localparam logic [2:0] B_T   = 3'd7;

	// accumulate modes applied in the cycle after the multiply
	localparam logic [2:0] M_CX_LOAD = 3'd0;
	localparam logic [2:0] M_CX_SUB  = 3'd1;
	localparam logic [2:0] M_SS50    = 3'd2;
	localparam logic [2:0] M_SS26    = 3'd3;
	localparam logic [2:0] M_SS0     = 3'd4;
	localparam logic [2:0] M_W32     = 3'd5;
	localparam logic [2:0] M_WADD    = 3'd6;
	localparam logic [2:0] M_W24     = 3'd7;

	localparam logic [5:0] TRI_LAST  = 6'd24;
	localparam logic [5:0] FIN_START = 6'd25;
	localparam logic [5:0] FIN_LAST  = 6'd33;

	typedef struct packed {
		logic [3:0] kind;
		logic [2:0] a_sel;
		logic [2:0] b_sel;
		logic [2:0] mode;
	} op_t;

	typedef struct packed {
		logic       vtx_we;
		logic [1:0] vtx_slot;
		logic       face_start;
		logic       face_bad;
		logic       op_en;
		op_t        op;
		logic [1:0] tri_sel;
		logic [2:0] face_n;
		logic       out_load;
		logic [1:0] out_idx;
		logic       out_last;
	} cmd_t;

	typedef struct packed {
		logic iter_done;
		logic out_free;
	} sts_t;

	function automatic op_t mk_op(input logic [3:0] kind, input logic [2:0] a_sel,
			input logic [2:0] b_sel, input logic [2:0] mode);
		op_t o;
		o.kind  = kind;
		o.a_sel = a_sel;
		o.b_sel = b_sel;
		o.mode  = mode;
		return o;
	endfunction

	// one triangle (0..24), then the diagonal and load terms (25..33)
	function automatic op_t rom(input logic [5:0] pc);
		op_t o;
		case (pc)
			6'd0:  o = mk_op(K_EDGE, A_U0, B_W0, M_CX_LOAD);
			6'd1:  o = mk_op(K_MUL,  A_U1, B_W2, M_CX_LOAD);
			6'd2:  o = mk_op(K_MUL,  A_U2, B_W1, M_CX_SUB);
			6'd3:  o = mk_op(K_NOP,  A_U0, B_W0, M_CX_LOAD);
			6'd4:  o = mk_op(K_MAG,  A_U0, B_W0, M_CX_LOAD);
			6'd5:  o = mk_op(K_MUL,  A_CH, B_CH, M_SS50);
			6'd6:  o = mk_op(K_MUL,  A_CH, B_CL, M_SS26);
			6'd7:  o = mk_op(K_MUL,  A_CL, B_CL, M_SS0);
			6'd8:  o = mk_op(K_MUL,  A_U2, B_W0, M_CX_LOAD);
			6'd9:  o = mk_op(K_MUL,  A_U0, B_W2, M_CX_SUB);
			6'd10: o = mk_op(K_NOP,  A_U0, B_W0, M_CX_LOAD);
			6'd11: o = mk_op(K_MAG,  A_U0, B_W0, M_CX_LOAD);
			6'd12: o = mk_op(K_MUL,  A_CH, B_CH, M_SS50);
			6'd13: o = mk_op(K_MUL,  A_CH, B_CL, M_SS26);
			6'd14: o = mk_op(K_MUL,  A_CL, B_CL, M_SS0);
			6'd15: o = mk_op(K_MUL,  A_U0, B_W1, M_CX_LOAD);
			6'd16: o = mk_op(K_MUL,  A_U1, B_W0, M_CX_SUB);
			6'd17: o = mk_op(K_NOP,  A_U0, B_W0, M_CX_LOAD);
			6'd18: o = mk_op(K_MAG,  A_U0, B_W0, M_CX_LOAD);
			6'd19: o = mk_op(K_MUL,  A_CH, B_CH, M_SS50);
			6'd20: o = mk_op(K_MUL,  A_CH, B_CL, M_SS26);
			6'd21: o = mk_op(K_MUL,  A_CL, B_CL, M_SS0);
			6'd22: o = mk_op(K_NOP,  A_U0, B_W0, M_CX_LOAD);
			6'd23: o = mk_op(K_SQRT, A_U0, B_W0, M_CX_LOAD);
			6'd24: o = mk_op(K_NSUM, A_U0, B_W0, M_CX_LOAD);
			6'd25: o = mk_op(K_MUL,  A_H,  B_AHI, M_W32);
			6'd26: o = mk_op(K_MUL,  A_H,  B_ALO, M_WADD);
			6'd27: o = mk_op(K_NOP,  A_U0, B_W0, M_CX_LOAD);
			6'd28: o = mk_op(K_DIV,  A_U0, B_W0, M_CX_LOAD);
			6'd29: o = mk_op(K_DSAT, A_U0, B_W0, M_CX_LOAD);
			6'd30: o = mk_op(K_MUL,  A_DH, B_T, M_W24);
			6'd31: o = mk_op(K_MUL,  A_DL, B_T, M_WADD);
			6'd32: o = mk_op(K_NOP,  A_U0, B_W0, M_CX_LOAD);
			6'd33: o = mk_op(K_LOAD, A_U0, B_W0, M_CX_LOAD);
			default: o = mk_op(K_NOP, A_U0, B_W0, M_CX_LOAD);
		endcase
		return o;
	endfunction

endpackage

// File: rtl/cflf_iter.sv
// Shared iterative unit: digit-by-digit square root and serial divide by a small count.
`timescale 1ns / 1ps
`include "convection_face_lumped_load_macros.svh"
module cflf_iter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start_sqrt,
	input  logic        start_div,
	input  logic [99:0] rad,
	input  logic [65:0] dividend,
	input  logic [2:0]  divisor,
	output logic [49:0] root,
	output logic [65:0] quot,
	output logic        done
);

	localparam logic [6:0] SQRT_LAST = 7'd49;
	localparam logic [6:0] DIV_LAST  = 7'd65;
	localparam logic MODE_SQRT = 1'b0;
	localparam logic MODE_DIV  = 1'b1;

	logic        busy_q, done_q, mode_q;
	logic [6:0]  cnt_q;
	logic [99:0] rad_q;
	logic [52:0] rem_q;
	logic [49:0] root_q;
	logic [65:0] quo_q;
	logic [1:0]  drem_q;
	logic [2:0]  dvs_q;

	logic [52:0] rem_t, trial;
	logic        rge;
	logic [2:0]  dt, dsub;
	logic        dge;

	always_comb begin
		rem_t = {rem_q[50:0], rad_q[99:98]};
		trial = {1'b0, root_q, 2'b01};
		rge   = rem_t >= trial;
		dt    = {drem_q, quo_q[65]};
		dge   = dt >= dvs_q;
		dsub  = dt - dvs_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			mode_q <= MODE_SQRT;
			cnt_q  <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (start_sqrt) begin
				busy_q <= 1'b1;
				mode_q <= MODE_SQRT;
				cnt_q  <= SQRT_LAST;
			end else if (start_div) begin
				busy_q <= 1'b1;
				mode_q <= MODE_DIV;
				cnt_q  <= DIV_LAST;
			end else if (busy_q) begin
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_sqrt) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (start_div) begin
			quo_q  <= dividend;
			drem_q <= 2'd0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			if (mode_q == MODE_SQRT) begin
				// two radicand bits in, one root bit out
				rad_q <= {rad_q[97:0], 2'b00};
				if (rge) begin
					rem_q  <= rem_t - trial;
					root_q <= {root_q[48:0], 1'b1};
				end else begin
					rem_q  <= rem_t;
					root_q <= {root_q[48:0], 1'b0};
				end
			end else begin
				quo_q  <= {quo_q[64:0], dge};
				drem_q <= dge ? dsub[1:0] : dt[1:0];
			end
		end
	end

	assign root = root_q;
	assign quot = quo_q;
	assign done = done_q;

	`CFLF_CHECK_IMP(a_start_idle, start_sqrt || start_div, !busy_q)
	`CFLF_CHECK(a_one_start, !(start_sqrt && start_div))
	`CFLF_CHECK_NXT(a_start_busy, start_sqrt || start_div, busy_q && !done_q)
	`CFLF_CHECK_NXT(a_done_pulse, done_q, !done_q && !busy_q)

endmodule

// File: rtl/cflf_ctrl.sv
// Controller: vertex counting, micro-program sequencing and result emission.
`timescale 1ns / 1ps
`include "convection_face_lumped_load_macros.svh"
module cflf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_last,
	output logic            in_ready,
	input  cflf_pkg::sts_t  sts,
	output cflf_pkg::cmd_t  cmd
);

	localparam logic [1:0] ST_COLLECT = 2'd0;
	localparam logic [1:0] ST_RUN     = 2'd1;
	localparam logic [1:0] ST_WAIT    = 2'd2;
	localparam logic [1:0] ST_EMIT    = 2'd3;

	logic [1:0] state_q;
	logic [2:0] cnt_q, n_q, stored_q;
	logic [5:0] pc_q;
	logic [1:0] tri_q, k_q;

	logic          in_fire, bad_now;
	logic [2:0]    cnt_inc, stored_now;
	cflf_pkg::op_t op;

	always_comb begin
		in_ready   = state_q == ST_COLLECT;
		in_fire    = in_valid && in_ready;
		cnt_inc    = (cnt_q == 3'd7) ? 3'd7 : cnt_q + 3'd1;
		bad_now    = !(cnt_inc == 3'd3 || cnt_inc == 3'd4);
		stored_now = (cnt_inc > 3'd4) ? 3'd4 : cnt_inc;
		op         = cflf_pkg::rom(pc_q);

		cmd            = '0;
		cmd.vtx_we     = in_fire && !cnt_q[2];
		cmd.vtx_slot   = cnt_q[1:0];
		cmd.face_start = in_fire && in_last;
		cmd.face_bad   = bad_now;
		cmd.op_en      = state_q == ST_RUN;
		cmd.op         = op;
		cmd.tri_sel    = tri_q;
		cmd.face_n     = n_q;
		cmd.out_load   = (state_q == ST_EMIT) && sts.out_free;
		cmd.out_idx    = k_q;
		cmd.out_last   = ({1'b0, k_q} + 3'd1) == stored_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_COLLECT;
			cnt_q    <= 3'd0;
			n_q      <= 3'd0;
			stored_q <= 3'd0;
			pc_q     <= 6'd0;
			tri_q    <= cflf_pkg::TRI_012;
			k_q      <= 2'd0;
		end else begin
			case (state_q)
				ST_COLLECT: begin
					if (in_fire) begin
						if (in_last) begin
							cnt_q    <= 3'd0;
							n_q      <= cnt_inc;
							stored_q <= stored_now;
							k_q      <= 2'd0;
							pc_q     <= 6'd0;
							tri_q    <= (cnt_inc == 3'd3) ? cflf_pkg::TRI_012
								: cflf_pkg::TRI_013;
							state_q  <= bad_now ? ST_EMIT : ST_RUN;
						end else begin
							cnt_q <= cnt_inc;
						end
					end
				end
				ST_RUN: begin
					if (op.kind == cflf_pkg::K_SQRT || op.kind == cflf_pkg::K_DIV) begin
						state_q <= ST_WAIT;
					end else if (pc_q == cflf_pkg::TRI_LAST) begin
						if (tri_q == cflf_pkg::TRI_013) begin
							tri_q <= cflf_pkg::TRI_123;
							pc_q  <= 6'd0;
						end else begin
							pc_q <= cflf_pkg::FIN_START;
						end
					end else if (pc_q == cflf_pkg::FIN_LAST) begin
						k_q     <= 2'd0;
						state_q <= ST_EMIT;
					end else begin
						pc_q <= pc_q + 6'd1;
					end
				end
				ST_WAIT: begin
					if (sts.iter_done) begin
						pc_q    <= pc_q + 6'd1;
						state_q <= ST_RUN;
					end
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						if (cmd.out_last)
							state_q <= ST_COLLECT;
						else
							k_q <= k_q + 2'd1;
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

	`CFLF_CHECK_NXT(a_cnt_clear, in_fire && in_last, cnt_q == 3'd0)
	`CFLF_CHECK_IMP(a_emit_count, state_q == ST_EMIT, stored_q != 3'd0 && stored_q <= 3'd4)
	`CFLF_CHECK_IMP(a_run_pc, state_q == ST_RUN, pc_q <= cflf_pkg::FIN_LAST)
	`CFLF_CHECK_IMP(a_quad_tri, state_q == ST_RUN && tri_q != cflf_pkg::TRI_012, n_q == 3'd4)

endmodule

// File: rtl/cflf_dp.sv
// Datapath: vertex store, shared multiplier, accumulators, config and output register.
`timescale 1ns / 1ps
module cflf_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic [23:0]         vertex_id,
	input  logic signed [23:0]  pos_x,
	input  logic signed [23:0]  pos_y,
	input  logic signed [23:0]  pos_z,
	input  logic                is_constrained,
	input  cflf_pkg::cmd_t      cmd,
	output cflf_pkg::sts_t      sts,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [23:0]         node_id,
	output logic [47:0]         diagonal_add,
	output logic [62:0]         load_add,
	output logic                applies,
	output logic                bad_shape,
	output logic                last_result
);

	logic [31:0] h_q, t_q;
	logic [24:0] nc_q;

	logic [23:0] crd_q [4][3];
	logic [23:0] ids_q [4];
	logic        fix_q [4];

	logic signed [24:0] u_q [3];
	logic signed [24:0] w_q [3];
	logic signed [50:0] cx_q;
	logic [48:0]        m_q;
	logic [99:0]        ss_q;
	logic [50:0]        ns_q;
	logic [81:0]        acc_q;
	logic [47:0]        diag_q;
	logic [62:0]        load_q;
	logic               bad_q;

	logic signed [65:0] prod_s1;
	logic               mul_s1;
	logic [2:0]         mode_s1;

	logic               out_valid_q;
	logic [23:0]        out_id_q;
	logic [47:0]        out_diag_q;
	logic [62:0]        out_load_q;
	logic               out_app_q, out_bad_q, out_last_q;

	logic [23:0]        ci [3];
	logic [23:0]        cj [3];
	logic [23:0]        ck [3];
	logic signed [32:0] opa, opb;
	logic signed [50:0] cx_neg;
	logic [49:0]        root;
	logic [65:0]        quot;
	logic               iter_done, start_sqrt, start_div, op_mul;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q  <= cflf_pkg::H_RESET;
			t_q  <= cflf_pkg::T_RESET;
			nc_q <= cflf_pkg::N_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				cflf_pkg::REG_H: h_q  <= cfg_data;
				cflf_pkg::REG_T: t_q  <= cfg_data;
				cflf_pkg::REG_N: nc_q <= cfg_data[24:0];
				default: ;
			endcase
		end
	end

	// triangle corners
	always_comb begin
		case (cmd.tri_sel)
			cflf_pkg::TRI_013: begin
				ci = crd_q[0]; cj = crd_q[1]; ck = crd_q[3];
			end
			cflf_pkg::TRI_123: begin
				ci = crd_q[1]; cj = crd_q[2]; ck = crd_q[3];
			end
			default: begin
				ci = crd_q[0]; cj = crd_q[1]; ck = crd_q[2];
			end
		endcase
	end

	always_comb begin
		case (cmd.op.a_sel)
			cflf_pkg::A_U0: opa = {{8{u_q[0][24]}}, u_q[0]};
			cflf_pkg::A_U1: opa = {{8{u_q[1][24]}}, u_q[1]};
			cflf_pkg::A_U2: opa = {{8{u_q[2][24]}}, u_q[2]};
			cflf_pkg::A_CH: opa = {9'd0, m_q[48:25]};
			cflf_pkg::A_CL: opa = {8'd0, m_q[24:0]};
			cflf_pkg::A_H:  opa = {1'b0, h_q};
			cflf_pkg::A_DH: opa = {9'd0, diag_q[47:24]};
			cflf_pkg::A_DL: opa = {9'd0, diag_q[23:0]};
			default:        opa = '0;
		endcase
		// area is half the norm sum, so its halves come straight off ns_q
		case (cmd.op.b_sel)
			cflf_pkg::B_W0:  opb = {{8{w_q[0][24]}}, w_q[0]};
			cflf_pkg::B_W1:  opb = {{8{w_q[1][24]}}, w_q[1]};
			cflf_pkg::B_W2:  opb = {{8{w_q[2][24]}}, w_q[2]};
			cflf_pkg::B_CH:  opb = {9'd0, m_q[48:25]};
			cflf_pkg::B_CL:  opb = {8'd0, m_q[24:0]};
			cflf_pkg::B_AHI: opb = {15'd0, ns_q[50:33]};
			cflf_pkg::B_ALO: opb = {1'b0, ns_q[32:1]};
			cflf_pkg::B_T:   opb = {1'b0, t_q};
			default:         opb = '0;
		endcase
		cx_neg     = -cx_q;
		op_mul     = cmd.op_en && cmd.op.kind == cflf_pkg::K_MUL;
		start_sqrt = cmd.op_en && cmd.op.kind == cflf_pkg::K_SQRT;
		start_div  = cmd.op_en && cmd.op.kind == cflf_pkg::K_DIV;
	end

	cflf_iter u_iter (
		.clk        (clk),
		.arst_n     (arst_n),
		.start_sqrt (start_sqrt),
		.start_div  (start_div),
		.rad        (ss_q),
		.dividend   (acc_q[81:16]),
		.divisor    (cmd.face_n),
		.root       (root),
		.quot       (quot),
		.done       (iter_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mul_s1 <= 1'b0;
		else
			mul_s1 <= op_mul;
	end

	always_ff @(posedge clk) begin
		prod_s1 <= opa * opb;
		mode_s1 <= cmd.op.mode;

		if (cmd.vtx_we) begin
			ids_q[cmd.vtx_slot]    <= vertex_id;
			fix_q[cmd.vtx_slot]    <= is_constrained;
			crd_q[cmd.vtx_slot][0] <= pos_x;
			crd_q[cmd.vtx_slot][1] <= pos_y;
			crd_q[cmd.vtx_slot][2] <= pos_z;
		end

		if (cmd.face_start) begin
			ns_q  <= '0;
			bad_q <= cmd.face_bad;
			if (cmd.face_bad) begin
				diag_q <= '0;
				load_q <= '0;
			end
		end

		if (cmd.op_en) begin
			case (cmd.op.kind)
				cflf_pkg::K_EDGE: begin
					for (int a = 0; a < 3; a++) begin
						u_q[a] <= $signed({cj[a][23], cj[a]}) - $signed({ci[a][23], ci[a]});
						w_q[a] <= $signed({ck[a][23], ck[a]}) - $signed({ci[a][23], ci[a]});
					end
					ss_q <= '0;
				end
				cflf_pkg::K_MAG:  m_q <= cx_q[50] ? cx_neg[48:0] : cx_q[48:0];
				cflf_pkg::K_NSUM: ns_q <= ns_q + {1'b0, root};
				cflf_pkg::K_DSAT: diag_q <= (|quot[65:48]) ? '1 : quot[47:0];
				cflf_pkg::K_LOAD: load_q <= (|acc_q[81:79]) ? '1 : acc_q[78:16];
				default: ;
			endcase
		end

		// accumulate the product issued in the previous cycle
		if (mul_s1) begin
			case (mode_s1)
				cflf_pkg::M_CX_LOAD: cx_q <= prod_s1[50:0];
				cflf_pkg::M_CX_SUB:  cx_q <= cx_q - $signed(prod_s1[50:0]);
				cflf_pkg::M_SS50:    ss_q <= ss_q + ({50'd0, prod_s1[49:0]} << 50);
				cflf_pkg::M_SS26:    ss_q <= ss_q + ({50'd0, prod_s1[49:0]} << 26);
				cflf_pkg::M_SS0:     ss_q <= ss_q + {50'd0, prod_s1[49:0]};
				cflf_pkg::M_W32:     acc_q <= {18'd0, prod_s1[63:0]} << 32;
				cflf_pkg::M_WADD:    acc_q <= acc_q + {18'd0, prod_s1[63:0]};
				cflf_pkg::M_W24:     acc_q <= {18'd0, prod_s1[63:0]} << 24;
				default: ;
			endcase
		end

		if (cmd.out_load) begin
			out_id_q   <= ids_q[cmd.out_idx];
			out_diag_q <= diag_q;
			out_load_q <= load_q;
			out_app_q  <= (h_q != 32'd0) && !fix_q[cmd.out_idx]
				&& ({1'b0, ids_q[cmd.out_idx]} < nc_q);
			out_bad_q  <= bad_q;
			out_last_q <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign sts.iter_done = iter_done;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign node_id      = out_id_q;
	assign diagonal_add = out_diag_q;
	assign load_add     = out_load_q;
	assign applies      = out_app_q;
	assign bad_shape    = out_bad_q;
	assign last_result  = out_last_q;

endmodule

// File: rtl/convection_face_lumped_load.sv
// Top level of the lumped convection face contribution block.
// Usage:
//  cfg channel: write h (index 0), ambient temperature (1) and node count (2);
//   always ready, write only while the block is idle.
//  in channel: one word per face vertex; last_vertex closes the face. Vertices
//   are taken one per cycle while a face is being collected.
//  out channel: one word per stored vertex (at most four), last_result on the
//   final one, held in an output register until taken.
// Triangles and quads run the shared multiplier sequence and the iterative unit
//  (50-step square root, 66-step divide) after the closing vertex; other shapes
//   go straight to emission. Words then leave one per cycle while out_ready
//   stays high.
// No new vertex is taken until the last word of a face is loaded into the
//  output register; a stalled receiver holds the block in its emit phase.
// Reset clears control state and loads the register defaults
//  (h = 0, 293.15 K, 2^24 nodes); stored vertices are not cleared.
`timescale 1ns / 1ps
module convection_face_lumped_load (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [23:0]        vertex_id,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] pos_z,
	input  logic               is_constrained,
	input  logic               last_vertex,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [23:0]        node_id,
	output logic [47:0]        diagonal_add,
	output logic [62:0]        load_add,
	output logic               applies,
	output logic               bad_shape,
	output logic               last_result
);

	cflf_pkg::cmd_t cmd;
	cflf_pkg::sts_t sts;

	cflf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (last_vertex),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cflf_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.vertex_id      (vertex_id),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.is_constrained (is_constrained),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.node_id        (node_id),
		.diagonal_add   (diagonal_add),
		.load_add       (load_add),
		.applies        (applies),
		.bad_shape      (bad_shape),
		.last_result    (last_result)
	);

endmodule
